// ----- src/lprd_pkg.sv -----
// ----------------------------------------------------------------------------
// lprd_pkg: shared types and constants of the record deframer
// Header layout, result kinds and the entry format of the internal queue.
// ----------------------------------------------------------------------------
package lprd_pkg;

  // Header is 24 bytes, little endian
  localparam int unsigned HdrBytes   = 24;
  localparam int unsigned CountWidth = 5;
  localparam logic [CountWidth-1:0] HdrLastPos = CountWidth'(HdrBytes - 1);

  // Expected magic word, bytes 0..3 of the header
  localparam logic [31:0] MagicWord = 32'h0046_4C54;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_DROP    = 2'd2
  } kind_e;

  // Captured header fields
  typedef struct packed {
    logic [31:0] sequence_number;
    logic [63:0] format_code;
    logic [31:0] delay_value;
    logic [31:0] payload_length;
  } header_t;

  // One classified result waiting in the queue
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    header_t     hdr;
  } entry_t;

endpackage

// ----- src/lprd_front.sv -----
// ----------------------------------------------------------------------------
// lprd_front: header collector and byte classifier
// Accepts one stream byte per cycle unless the queue is full, assembles the
// header, checks the magic and makes each result-bearing byte a queue entry.
// ----------------------------------------------------------------------------
module lprd_front import lprd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       q_full_i,
  output logic       q_wr_o,
  output entry_t     q_entry_o
);

  logic                  in_payload_q, in_payload_d;
  logic [CountWidth-1:0] hdr_count_q, hdr_count_d;
  logic [31:0]           magic_q, magic_d;
  header_t               hdr_q, hdr_d;
  logic [31:0]           remain_q, remain_d;
  logic [CountWidth-1:0] pos;
  logic                  accept;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  // Out-of-range counter restarts at the first header byte
  assign pos = (hdr_count_q > HdrLastPos) ? '0 : hdr_count_q;

  // Header capture, payload countdown and entry build
  always_comb begin
    in_payload_d = in_payload_q;
    hdr_count_d  = hdr_count_q;
    magic_d      = magic_q;
    hdr_d        = hdr_q;
    remain_d     = remain_q;
    q_wr_o       = 1'b0;
    q_entry_o    = '{kind: KIND_PAYLOAD, data: data_byte_i, last: 1'b0, hdr: hdr_q};

    if (accept) begin
      if (in_payload_q) begin
        remain_d       = remain_q - 32'd1;
        q_entry_o.last = (remain_d == '0);
        q_wr_o         = 1'b1;
        if (remain_d == '0) begin
          in_payload_d = 1'b0;
        end
      end else begin
        // Byte lands in its header field
        if (pos < CountWidth'(4)) begin
          magic_d[pos[1:0]*8 +: 8] = data_byte_i;
        end else if (pos < CountWidth'(8)) begin
          hdr_d.sequence_number[pos[1:0]*8 +: 8] = data_byte_i;
        end else if (pos < CountWidth'(16)) begin
          hdr_d.format_code[pos[2:0]*8 +: 8] = data_byte_i;
        end else if (pos < CountWidth'(20)) begin
          hdr_d.delay_value[pos[1:0]*8 +: 8] = data_byte_i;
        end else begin
          hdr_d.payload_length[pos[1:0]*8 +: 8] = data_byte_i;
        end

        if (pos == HdrLastPos) begin
          // Header complete: classify
          hdr_count_d     = '0;
          q_entry_o.hdr   = hdr_d;
          q_entry_o.data  = '0;
          q_entry_o.last  = 1'b1;
          if (magic_q != MagicWord) begin
            q_entry_o.kind = KIND_DROP;
            q_wr_o         = 1'b1;
          end else if (hdr_d.payload_length == '0) begin
            q_entry_o.kind = KIND_EMPTY;
            q_wr_o         = 1'b1;
          end else begin
            in_payload_d = 1'b1;
            remain_d     = hdr_d.payload_length;
          end
        end else begin
          hdr_count_d = pos + CountWidth'(1);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_count_q  <= '0;
      magic_q      <= '0;
      hdr_q        <= '0;
      remain_q     <= '0;
    end else begin
      in_payload_q <= in_payload_d;
      hdr_count_q  <= hdr_count_d;
      magic_q      <= magic_d;
      hdr_q        <= hdr_d;
      remain_q     <= remain_d;
    end
  end

endmodule

// ----- src/lprd_queue.sv -----
// ----------------------------------------------------------------------------
// lprd_queue: short entry queue between front and back
// Circular buffer; per cycle one write if not full and one read if not empty.
// ----------------------------------------------------------------------------
module lprd_queue import lprd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  entry_t wr_entry_i,
  output logic   full_o,
  input  logic   rd_i,
  output entry_t rd_entry_o,
  output logic   empty_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] PtrMax = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

  entry_t                mem_q [Depth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  do_wr, do_rd;

  assign full_o     = (count_q == CntFull);
  assign empty_o    = (count_q == '0);
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && !empty_o;
  assign rd_entry_o = mem_q[rd_ptr_q];

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntWidth'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

// ----- src/lprd_back.sv -----
// ----------------------------------------------------------------------------
// lprd_back: result formatter and output register
// Pulls entries from the queue, masks fields of dropped headers and holds
// the oldest result until it is popped.
// ----------------------------------------------------------------------------
module lprd_back import lprd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_empty_i,
  input  entry_t       q_entry_i,
  output logic         q_rd_o,
  output logic         empty,
  input  logic         pop,
  output logic [1:0]   kind_o,
  output logic [7:0]   payload_byte_o,
  output logic         last_o,
  output logic [31:0]  sequence_number_o,
  output logic [63:0]  format_code_o,
  output logic [31:0]  delay_value_o,
  output logic [31:0]  payload_length_o
);

  logic   valid_q, valid_d;
  entry_t out_q, out_d;
  logic   load;

  // Refill the output register when it is free or being popped
  assign load   = !valid_q || pop;
  assign q_rd_o = load && !q_empty_i;

  always_comb begin
    valid_d = valid_q;
    out_d   = out_q;
    if (load) begin
      valid_d = !q_empty_i;
      out_d   = q_entry_i;
      case (q_entry_i.kind)
        KIND_DROP: begin
          out_d.data = '0;
          out_d.hdr  = '0;
        end
        KIND_EMPTY: begin
          out_d.data = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty             = !valid_q;
  assign kind_o            = out_q.kind;
  assign payload_byte_o    = out_q.data;
  assign last_o            = out_q.last;
  assign sequence_number_o = out_q.hdr.sequence_number;
  assign format_code_o     = out_q.hdr.format_code;
  assign delay_value_o     = out_q.hdr.delay_value;
  assign payload_length_o  = out_q.hdr.payload_length;

endmodule

// ----- src/length_prefixed_record_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer: byte stream to record results
//
//   channel   handshake      payload
//   input     push / full    data_byte_i
//   result    empty / pop    kind_o, payload_byte_o, last_o, sequence_number_o,
//                            format_code_o, delay_value_o, payload_length_o
//
// One byte is taken per cycle unless the queue is full, header and payload
// bytes alike. A result's entry is written to the queue at the edge that
// takes its byte and moves to the output register when that is free or popped.
// full rises only when the entry queue is full; the output register refills in
// the cycle it is popped, so with entries queued results flow at one per cycle.
// Reset clears the header collector, payload counter, queue and output valid.
// ----------------------------------------------------------------------------
module length_prefixed_record_deframer import lprd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  logic [7:0]   data_byte_i,
  output logic         empty,
  input  logic         pop,
  output logic [1:0]   kind_o,
  output logic [7:0]   payload_byte_o,
  output logic         last_o,
  output logic [31:0]  sequence_number_o,
  output logic [63:0]  format_code_o,
  output logic [31:0]  delay_value_o,
  output logic [31:0]  payload_length_o
);

  logic   q_wr, q_full, q_rd, q_empty;
  entry_t q_wr_entry, q_rd_entry;

  lprd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr),
    .q_entry_o   (q_wr_entry)
  );

  lprd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_entry_i (q_wr_entry),
    .full_o     (q_full),
    .rd_i       (q_rd),
    .rd_entry_o (q_rd_entry),
    .empty_o    (q_empty)
  );

  lprd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_entry_i         (q_rd_entry),
    .q_rd_o            (q_rd),
    .empty             (empty),
    .pop               (pop),
    .kind_o            (kind_o),
    .payload_byte_o    (payload_byte_o),
    .last_o            (last_o),
    .sequence_number_o (sequence_number_o),
    .format_code_o     (format_code_o),
    .delay_value_o     (delay_value_o),
    .payload_length_o  (payload_length_o)
  );

endmodule

// ----- tb/length_prefixed_record_deframer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer_tb: self-checking bench for the deframer
// Feeds byte beats through the push/full side and pops results from the
// empty/pop side, both with random stalls. A behavioral deframer computes
// the expected result for each accepted byte; a short directed table comes
// first, then random well-formed records mixed with bad and noisy headers.
// ----------------------------------------------------------------------------
module length_prefixed_record_deframer_tb;
  import lprd_pkg::*;

  localparam int unsigned ItemTarget  = 1800;
  localparam int unsigned MaxGap      = 18;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  // One result beat as the block presents it
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic        last;
    header_t     hdr;
  } record_result_t;

  // One stimulus byte, optionally with a hand-written expected result
  typedef struct packed {
    logic [7:0]     data;
    bit             pinned;
    record_result_t result;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte_i;
  logic        empty;
  logic        pop;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic        last_o;
  logic [31:0] sequence_number_o;
  logic [63:0] format_code_o;
  logic [31:0] delay_value_o;
  logic [31:0] payload_length_o;

  length_prefixed_record_deframer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .data_byte_i       (data_byte_i),
    .empty             (empty),
    .pop               (pop),
    .kind_o            (kind_o),
    .payload_byte_o    (payload_byte_o),
    .last_o            (last_o),
    .sequence_number_o (sequence_number_o),
    .format_code_o     (format_code_o),
    .delay_value_o     (delay_value_o),
    .payload_length_o  (payload_length_o)
  );

  // Deframer state mirrored by the bench
  logic        in_payload_q;
  logic [4:0]  hdr_pos_q;
  logic [31:0] magic_q;
  header_t     hdr_q;
  logic [31:0] remaining_q;

  stim_row_t      stim_rows[$];
  record_result_t expected_results[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned payload_seen;
  int unsigned empty_seen;
  int unsigned drop_seen;
  bit          src_burst;
  bit          snk_burst;
  bit          draining;

  always #6 clk_i = ~clk_i;

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Behavioral deframer: consume one byte, maybe produce one result
  function automatic void deframe_byte(input logic [7:0] b, output bit produced,
                                       output record_result_t r);
    int pos;
    produced = 1'b0;
    r = record_result_t'{KIND_PAYLOAD, 8'h00, 1'b0, header_t'(0)};
    if (in_payload_q) begin
      remaining_q = remaining_q - 32'd1;
      r.payload   = b;
      r.last      = (remaining_q == 32'd0);
      r.hdr       = hdr_q;
      if (r.last) in_payload_q = 1'b0;
      produced = 1'b1;
      return;
    end
    // out-of-range counter restarts the header
    pos = (hdr_pos_q >= HdrBytes) ? 0 : int'(hdr_pos_q);
    if (pos < 4) magic_q[pos*8 +: 8] = b;
    else if (pos < 8) hdr_q.sequence_number[(pos-4)*8 +: 8] = b;
    else if (pos < 16) hdr_q.format_code[(pos-8)*8 +: 8] = b;
    else if (pos < 20) hdr_q.delay_value[(pos-16)*8 +: 8] = b;
    else hdr_q.payload_length[(pos-20)*8 +: 8] = b;
    pos++;
    if (pos < HdrBytes) begin
      hdr_pos_q = 5'(pos);
      return;
    end
    hdr_pos_q = '0;
    if (magic_q != MagicWord) begin
      r.kind   = KIND_DROP;
      r.last   = 1'b1;
      produced = 1'b1;
    end else if (hdr_q.payload_length == 32'd0) begin
      r.kind   = KIND_EMPTY;
      r.last   = 1'b1;
      r.hdr    = hdr_q;
      produced = 1'b1;
    end else begin
      in_payload_q = 1'b1;
      remaining_q  = hdr_q.payload_length;
    end
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    stim_row_t row;
    row        = '0;
    row.data   = b;
    stim_rows.push_back(row);
  endfunction

  // Queue a 24-byte header; the final byte may carry a fixed expectation
  function automatic void add_header(input logic [31:0] magic, input header_t h,
                                     input bit pin, input kind_e pin_kind);
    logic [191:0] raw;
    stim_row_t    row;
    int           i;
    raw = {h.payload_length, h.delay_value, h.format_code, h.sequence_number, magic};
    for (i = 0; i < HdrBytes - 1; i++) add_byte(raw[i*8 +: 8]);
    row        = '0;
    row.data   = raw[(HdrBytes-1)*8 +: 8];
    row.pinned = pin;
    row.result = record_result_t'{pin_kind, 8'h00, 1'b1,
                                  (pin_kind == KIND_DROP) ? header_t'(0) : h};
    stim_rows.push_back(row);
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Drive one byte beat; predict on acceptance
  task automatic send_row(input stim_row_t row);
    int             gap;
    bit             produced;
    record_result_t predicted;
    gap = src_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= row.data;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    deframe_byte(row.data, produced, predicted);
    if (row.pinned) expected_results.push_back(row.result);
    else if (produced) expected_results.push_back(predicted);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_all_rows();
    while (stim_rows.size() != 0) send_row(stim_rows.pop_front());
  endtask

  // Result side: pop with random stalls, compare against oldest expectation
  initial begin
    int             gap;
    record_result_t want;
    pop = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = (snk_burst || draining) ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, kind %0d byte %0h", $time, kind_o,
                 payload_byte_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("kind", want.kind, kind_o);
        compare_field("payload_byte", want.payload, payload_byte_o);
        compare_field("last", want.last, last_o);
        compare_field("sequence_number", want.hdr.sequence_number, sequence_number_o);
        compare_field("format_code", want.hdr.format_code, format_code_o);
        compare_field("delay_value", want.hdr.delay_value, delay_value_o);
        compare_field("payload_length", want.hdr.payload_length, payload_length_o);
      end
      case (kind_o)
        KIND_PAYLOAD: payload_seen++;
        KIND_EMPTY:   empty_seen++;
        default:      drop_seen++;
      endcase
      results_seen++;
      if (results_seen % 40 == 0) snk_burst = ($urandom_range(0, 3) == 0);
      @(negedge clk_i);
    end
  end

  // Reset, directed table, random records, drain
  initial begin
    header_t     h;
    logic [31:0] magic;
    int          choice;
    int          len;
    int          pick;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    push         = 1'b0;
    data_byte_i  = 8'h00;
    cycle_count  = 0;
    error_count  = 0;
    bytes_sent   = 0;
    results_seen = 0;
    payload_seen = 0;
    empty_seen   = 0;
    drop_seen    = 0;
    src_burst    = 1'b0;
    snk_burst    = 1'b0;
    draining     = 1'b0;
    in_payload_q = 1'b0;
    hdr_pos_q    = '0;
    magic_q      = '0;
    hdr_q        = '0;
    remaining_q  = '0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: bad magic with all ones, near-miss magic, empty record with
    // all-ones fields, short records with extreme payload bytes
    add_header(32'hFFFF_FFFF, header_t'('1), 1'b1, KIND_DROP);
    add_header(MagicWord ^ 32'h0100_0000, header_t'(0), 1'b1, KIND_DROP);
    add_header(MagicWord, header_t'{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                    32'hFFFF_FFFF, 32'd0}, 1'b1, KIND_EMPTY);
    add_header(MagicWord, header_t'{32'd0, 64'd0, 32'd0, 32'd2}, 1'b0, KIND_PAYLOAD);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_header(MagicWord, header_t'{32'd1, 64'h8000_0000_0000_0000, 32'h8000_0000,
                                    32'd1}, 1'b0, KIND_PAYLOAD);
    add_byte(8'hA5);
    send_all_rows();

    // Random: mostly good records, some near-miss magic, some pure noise
    while (bytes_sent < ItemTarget) begin
      src_burst = ($urandom_range(0, 7) == 0);
      choice    = $urandom_range(0, 99);
      h.sequence_number = $urandom;
      h.format_code     = {$urandom, $urandom};
      h.delay_value     = $urandom;
      if (choice < 78) begin
        pick = $urandom_range(0, 19);
        if (pick < 3) len = 0;
        else if (pick < 17) len = $urandom_range(1, 8);
        else len = $urandom_range(9, 48);
        if ($urandom_range(0, 49) == 0) len = $urandom_range(250, 300);
        h.payload_length = len;
        add_header(MagicWord, h, 1'b0, KIND_PAYLOAD);
        repeat (len) add_byte(8'($urandom));
      end else begin
        if (choice < 92) magic = MagicWord ^ (32'h1 << $urandom_range(0, 31));
        else magic = $urandom;
        if (magic == MagicWord) magic = ~magic;
        h.payload_length = $urandom;
        add_header(magic, h, 1'b0, KIND_PAYLOAD);
      end
      send_all_rows();
    end

    // A record left open with the largest length
    h.sequence_number = $urandom;
    h.format_code     = {$urandom, $urandom};
    h.delay_value     = $urandom;
    h.payload_length  = 32'hFFFF_FFFF;
    add_header(MagicWord, h, 1'b0, KIND_PAYLOAD);
    repeat (6) add_byte(8'($urandom));
    send_all_rows();
    push <= 1'b0;

    draining = 1'b1;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d byte beats in, %0d results: %0d payload, %0d empty, %0d dropped",
             bytes_sent, results_seen, payload_seen, empty_seen, drop_seen);
    $display("random stalls on both sides, bursts, and an open all-ones length record");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- length_prefixed_record_deframer.f -----
src/lprd_pkg.sv
src/lprd_front.sv
src/lprd_queue.sv
src/lprd_back.sv
src/length_prefixed_record_deframer.sv
tb/length_prefixed_record_deframer_tb.sv
